// ===== src/ffc_pkg.sv =====
// Shared types and constants for the four-function calculator readout.
// Depends on nothing; used by every module of the block.
`default_nettype none
package ffc_pkg;

    localparam logic [2:0] FUNC_ADD = 3'd1;
    localparam logic [2:0] FUNC_SUB = 3'd2;
    localparam logic [2:0] FUNC_MUL = 3'd3;
    localparam logic [2:0] FUNC_DIV = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FAULT   = 2'd2;

    localparam logic [1:0] NUM_A   = 2'd0;
    localparam logic [1:0] NUM_B   = 2'd1;
    localparam logic [1:0] NUM_RES = 2'd2;

    localparam logic [3:0] POS_LAST = 4'd9;
    localparam int unsigned DIV_STEPS = 32;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
    } ffc_entry_t;

    // place value for digit positions, billions first
    function automatic logic [29:0] place_scale(input logic [3:0] pos);
        logic [29:0] s;
        unique case (pos)
            4'd0:    s = 30'd1000000000;
            4'd1:    s = 30'd100000000;
            4'd2:    s = 30'd10000000;
            4'd3:    s = 30'd1000000;
            4'd4:    s = 30'd100000;
            4'd5:    s = 30'd10000;
            4'd6:    s = 30'd1000;
            4'd7:    s = 30'd100;
            4'd8:    s = 30'd10;
            default: s = 30'd1;
        endcase
        return s;
    endfunction

    // bit0 = a ... bit6 = g
    function automatic logic [6:0] seg_pattern(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7C;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== src/ffc_front.sv =====
// Front end: accepts requests, classifies them and computes the result
// (serial restoring divider for divide). Depends on ffc_pkg.
`default_nettype none
module ffc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [2:0]        func,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    input  wire logic              q_full,
    output logic                   q_push,
    output ffc_pkg::ffc_entry_t    q_entry
);
    import ffc_pkg::*;

    logic        valid_reg, valid_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  func_reg;
    logic [1:0]  stat_reg;
    logic [31:0] a_reg, b_reg;
    logic        neg_reg;
    logic [31:0] dq_reg, drem_reg, dvs_reg;
    logic [32:0] trial;
    logic        accept;
    logic [31:0] mag_a, mag_b;
    logic [31:0] res;
    logic [1:0]  stat_in;
    logic [63:0] prod;

    assign q_push = valid_reg && (cnt_reg == 6'd0) && !q_full;
    assign full   = valid_reg && !q_push;
    assign accept = push && !full;

    assign mag_a = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
    assign mag_b = operand_b[31] ? (~operand_b + 32'd1) : operand_b;

    always_comb
    begin
        if (func == 3'd0 || func > FUNC_DIV)
            stat_in = STAT_INVALID;
        else if (func == FUNC_DIV && (operand_b == 32'd0 ||
                 (operand_a == 32'h8000_0000 && operand_b == 32'hFFFF_FFFF)))
            stat_in = STAT_FAULT;
        else
            stat_in = STAT_OK;
    end

    assign trial = {drem_reg, dq_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            cnt_next   = (func == FUNC_DIV && stat_in == STAT_OK) ? 6'(DIV_STEPS) : 6'd0;
        end
        else
        begin
            if (q_push)
                valid_next = 1'b0;
            if (cnt_reg != 6'd0)
                cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            stat_reg <= stat_in;
            a_reg    <= operand_a;
            b_reg    <= operand_b;
            neg_reg  <= operand_a[31] ^ operand_b[31];
            dq_reg   <= mag_a;
            drem_reg <= 32'd0;
            dvs_reg  <= mag_b;
        end
        else if (cnt_reg != 6'd0)
        begin
            // one quotient bit per cycle
            if (!trial[32])
            begin
                drem_reg <= trial[31:0];
                dq_reg   <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[30:0], dq_reg[31]};
                dq_reg   <= {dq_reg[30:0], 1'b0};
            end
        end
    end

    assign prod = a_reg * b_reg;

    always_comb
    begin
        unique case (func_reg)
            FUNC_ADD: res = a_reg + b_reg;
            FUNC_SUB: res = a_reg - b_reg;
            FUNC_MUL: res = prod[31:0];
            FUNC_DIV: res = neg_reg ? (~dq_reg + 32'd1) : dq_reg;
            default:  res = 32'd0;
        endcase
    end

    always_comb
    begin
        q_entry.status = stat_reg;
        q_entry.a      = a_reg;
        q_entry.b      = b_reg;
        q_entry.r      = res;
    end

endmodule
`default_nettype wire

// ===== src/ffc_queue.sv =====
// Two-entry queue between front and back end.
// Depends on ffc_pkg for the entry type.
`default_nettype none
module ffc_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr,
    input  wire ffc_pkg::ffc_entry_t wr_data,
    output logic                     q_full,
    input  wire logic                rd,
    output ffc_pkg::ffc_entry_t      rd_data,
    output logic                     q_nonempty
);
    import ffc_pkg::*;

    ffc_entry_t mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign q_full     = (cnt_reg == 2'd2);
    assign q_nonempty = (cnt_reg != 2'd0);
    assign rd_data    = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 2'd1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ===== src/ffc_back.sv =====
// Back end: turns queued entries into digit items or a status item, one per cycle
// while the output register is empty or being popped, into that register. Depends on ffc_pkg.
`default_nettype none
module ffc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_nonempty,
    input  wire ffc_pkg::ffc_entry_t q_entry,
    output logic                     q_pop,
    input  wire logic                pop,
    output logic                     empty,
    output logic [1:0]               which_number,
    output logic [3:0]               digit_position,
    output logic [6:0]               segments,
    output logic                     digit_error,
    output logic [1:0]               status,
    output logic                     last
);
    import ffc_pkg::*;

    logic        active_reg;
    logic        ovalid_reg;
    logic [1:0]  which_reg;
    logic [3:0]  pos_reg;
    logic [31:0] rem_reg;
    logic        neg_reg;
    logic [31:0] b_reg, r_reg;

    logic        can_emit, step;
    logic [31:0] cur_rem;
    logic        cur_neg;
    logic [1:0]  cur_which;
    logic [3:0]  cur_pos;
    logic [33:0] scale;
    logic [33:0] sub;
    logic [3:0]  d;
    logic [31:0] new_rem;
    logic [31:0] next_val;
    logic        stat_item;

    assign can_emit  = !ovalid_reg || pop;
    assign step      = can_emit && (active_reg || q_nonempty);
    assign stat_item = !active_reg && (q_entry.status != STAT_OK);
    assign q_pop     = can_emit && !active_reg && q_nonempty;

    always_comb
    begin
        if (active_reg)
        begin
            cur_rem   = rem_reg;
            cur_neg   = neg_reg;
            cur_which = which_reg;
            cur_pos   = pos_reg;
        end
        else
        begin
            cur_rem   = q_entry.a[31] ? (~q_entry.a + 32'd1) : q_entry.a;
            cur_neg   = q_entry.a[31];
            cur_which = NUM_A;
            cur_pos   = 4'd0;
        end
    end

    // digit = largest k with k*scale <= remainder
    always_comb
    begin
        scale = {4'd0, place_scale(cur_pos)};
        d     = 4'd0;
        sub   = 34'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({2'b00, cur_rem} >= scale * 34'(k))
            begin
                d   = 4'(k);
                sub = scale * 34'(k);
            end
        end
        new_rem = cur_rem - sub[31:0];
    end

    assign next_val = (which_reg == NUM_A) ? b_reg : r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            which_reg  <= NUM_A;
            pos_reg    <= 4'd0;
        end
        else
        begin
            if (step)
                ovalid_reg <= 1'b1;
            else if (pop)
                ovalid_reg <= 1'b0;
            if (step && !stat_item)
            begin
                if (!active_reg)
                begin
                    active_reg <= 1'b1;
                    which_reg  <= NUM_A;
                    pos_reg    <= 4'd1;
                end
                else if (pos_reg == POS_LAST)
                begin
                    pos_reg <= 4'd0;
                    if (which_reg == NUM_RES)
                        active_reg <= 1'b0;
                    else
                        which_reg <= which_reg + 2'd1;
                end
                else
                    pos_reg <= pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_reg <= q_entry.b;
            r_reg <= q_entry.r;
        end
        if (step && !stat_item)
        begin
            if (active_reg && pos_reg == POS_LAST)
            begin
                rem_reg <= next_val[31] ? (~next_val + 32'd1) : next_val;
                neg_reg <= next_val[31];
            end
            else
            begin
                rem_reg <= new_rem;
                neg_reg <= cur_neg;
            end
        end
        if (step)
        begin
            if (stat_item)
            begin
                which_number   <= NUM_A;
                digit_position <= 4'd0;
                segments       <= 7'd0;
                digit_error    <= 1'b0;
                status         <= q_entry.status;
                last           <= 1'b1;
            end
            else
            begin
                which_number   <= cur_which;
                digit_position <= cur_pos;
                segments       <= (cur_neg && d != 4'd0) ? 7'd0 : seg_pattern(d);
                digit_error    <= cur_neg && d != 4'd0;
                status         <= STAT_OK;
                last           <= (cur_which == NUM_RES) && (cur_pos == POS_LAST);
            end
        end
    end

    assign empty = !ovalid_reg;

endmodule
`default_nettype wire

// ===== src/four_function_calc_seven_segment.sv =====
// Four-function calculator with seven-segment decimal readout, top level.
// Instantiates ffc_front, ffc_queue and ffc_back; depends on ffc_pkg.
//
// Input side is a queue: present func/operand_a/operand_b with push; the
// request is taken on a clock edge with push high and full low.
// Result side is a queue: while empty is low the oldest result sits on the
// output ports and is taken on an edge with pop high.
// A valid request yields 30 digit items (operand_a, operand_b, result, ten
// places each, billions first), last set on the final one. An invalid
// function or a divide fault yields one status item with last set.
// A request is registered in the front end, written to the queue and then
// registered as its first item in the output register; a divide first runs the one-bit-per-cycle divider.
// The back end emits one item per cycle while pop keeps up and moves straight
// on to the next queued request; the two-entry queue lets the front accept
// and compute (including a divide) while the back end drains digits.
// When pop stays low the output register holds, the back end stops, the
// queue fills and full rises. Reset clears all control state; the block
// comes up empty and ready.
`default_nettype none
module four_function_calc_seven_segment (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         func,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              which_number,
    output logic [3:0]              digit_position,
    output logic [6:0]              segments,
    output logic                    digit_error,
    output logic [1:0]              status,
    output logic                    last
);
    import ffc_pkg::*;

    ffc_entry_t f_entry, b_entry;
    logic       q_push, q_full, q_pop, q_nonempty;

    ffc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (f_entry)
    );

    ffc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (q_push),
        .wr_data    (f_entry),
        .q_full     (q_full),
        .rd         (q_pop),
        .rd_data    (b_entry),
        .q_nonempty (q_nonempty)
    );

    ffc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_nonempty     (q_nonempty),
        .q_entry        (b_entry),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .which_number   (which_number),
        .digit_position (digit_position),
        .segments       (segments),
        .digit_error    (digit_error),
        .status         (status),
        .last           (last)
    );

    // status items always close their request
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != STAT_OK) |-> last)
        else $error("status item without last");

    // last on a digit item only at the units place of the result
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == STAT_OK && last) |->
        (which_number == NUM_RES && digit_position == POS_LAST))
        else $error("last on wrong digit");

    // an error digit is always blank
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && digit_error) |-> (segments == 7'd0))
        else $error("error digit lit");

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digit_position) && $stable(which_number)))
        else $error("stalled result changed");

endmodule
`default_nettype wire
